// ===== hdl/ffpa_pkg.sv =====
// shared constants and types for the first-fit paged allocator
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam int NUM_PAGES    = 12;
    localparam int PAGE_BYTES   = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_SEGMENTS = 64;
    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int ADDR_W  = 14;
    localparam int SIZE_W  = 10;
    localparam int SLOT_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int MAX_SIZE = PAGE_BYTES - HEADER_BYTES - 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] first;
        logic [OFF_W-1:0] last;
    } t_seg;
endpackage

// ===== hdl/ffpa_cell.sv =====
// one segment cell of the free list chain
`timescale 1ns / 1ps
module ffpa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ffpa_pkg::t_seg i_load_seg,
    input  ffpa_pkg::t_seg i_prev,
    input  logic           i_shift,
    output ffpa_pkg::t_seg o_seg
);
    ffpa_pkg::t_seg r_seg, n_seg;

    always_comb begin
        n_seg = r_seg;
        if (i_load) begin
            n_seg = i_load_seg;
        end else if (i_shift) begin
            n_seg = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
            r_seg.first <= '0;
            r_seg.last  <= '0;
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;
endmodule

// ===== hdl/first_fit_paged_allocator.sv =====
// top level: first-fit paged allocator with segment merging
`timescale 1ns / 1ps
// One transaction at a time: a transaction is taken when i_start is high and
// o_busy is low, and exactly one result follows with a one-cycle o_done strobe
// that cannot be held off. A page's free list lives in a segment memory; a free
// reads and merges it segment by segment and streams the merged list through a
// shift chain of MAX_SEGMENTS cells back into memory.
// The size store and segment memories have no clearing pass.
module first_fit_paged_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_cmd,
    input  logic [9:0]                  i_req_size,
    input  logic [13:0]                 i_free_addr,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [13:0]                 o_block_addr,
    output logic [1:0]                  o_status
);
    localparam int PW = ffpa_pkg::PAGE_W;
    localparam int OW = ffpa_pkg::OFF_W;
    localparam int SW = ffpa_pkg::SLOT_W;
    localparam int CW = ffpa_pkg::CNT_W;
    localparam int NS = ffpa_pkg::MAX_SEGMENTS;
    localparam int SEGD = ffpa_pkg::NUM_PAGES * ffpa_pkg::MAX_SEGMENTS;
    localparam int BSD  = ffpa_pkg::NUM_PAGES * ffpa_pkg::PAGE_BYTES;
    localparam int SAW = $clog2(SEGD);
    localparam int BAW = $clog2(BSD);
    localparam int LW  = OW + ffpa_pkg::SIZE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_A_PAGE, S_A_RD, S_A_CHK, S_A_WR, S_F_HDR, S_F_HDR2,
        S_F_RD, S_F_MRG, S_F_OUT, S_F_WR, S_DONE
    } t_state;

    t_state r_state;
    logic [ffpa_pkg::SIZE_W-1:0] r_size;
    logic [PW-1:0] r_page;
    logic [OW-1:0] r_hs;
    logic [OW:0]   r_need;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_k;
    logic          r_placed;
    logic          r_have;
    logic [OW-1:0] r_tf, r_tl;
    logic [OW-1:0] r_nf, r_nl;
    logic          r_nvalid;
    logic [OW-1:0] r_if, r_il;
    logic [13:0]   r_addr;
    logic [1:0]    r_status;
    logic          r_done;

    logic          r_open [ffpa_pkg::NUM_PAGES];
    logic [CW-1:0] r_cnt  [ffpa_pkg::NUM_PAGES];

    // segment memory
    logic [2*OW-1:0] r_segmem [SEGD];
    logic [2*OW-1:0] r_segrd;
    logic            seg_we;
    logic [SAW-1:0]  seg_wa, seg_ra;
    logic [2*OW-1:0] seg_wd;
    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_segmem[seg_wa] <= seg_wd;
        end
        r_segrd <= r_segmem[seg_ra];
    end

    // size store
    logic [ffpa_pkg::SIZE_W-1:0] r_bsmem [BSD];
    logic [ffpa_pkg::SIZE_W-1:0] r_bsrd;
    logic                        bs_we;
    logic [BAW-1:0]              bs_wa, bs_ra;
    always_ff @(posedge i_clk) begin
        if (bs_we) begin
            r_bsmem[bs_wa] <= r_size;
        end
        r_bsrd <= r_bsmem[bs_ra];
    end

    // cell chain holding merged output segments of a free
    ffpa_pkg::t_seg chain [NS];
    ffpa_pkg::t_seg chain_in;
    logic           chain_shift;
    logic           chain_clr;
    ffpa_pkg::t_seg clr_seg;
    assign clr_seg = '{valid: 1'b0, first: '0, last: '0};

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_cell
            ffpa_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_load     (chain_clr),
                .i_load_seg (clr_seg),
                .i_prev     ((g == 0) ? chain_in : chain[(g == 0) ? 0 : g-1]),
                .i_shift    (chain_shift),
                .o_seg      (chain[g])
            );
        end
    endgenerate

    function automatic logic [SAW-1:0] seg_addr(input logic [PW-1:0] p,
                                                input logic [SW-1:0] s);
        return SAW'(p * NS + s);
    endfunction

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = r_cnt[r_page];

    logic [OW-1:0] rd_f, rd_l;
    assign rd_f = r_segrd[2*OW-1:OW];
    assign rd_l = r_segrd[OW-1:0];

    logic [OW:0] seg_len;
    assign seg_len = {1'b0, rd_l} - {1'b0, rd_f} + (OW+1)'(1);

    logic [LW-1:0] last_sum;
    assign last_sum = LW'(r_hs) + LW'(r_bsrd) + LW'(ffpa_pkg::HEADER_BYTES - 1);

    // merge step: candidate (f,l) against accumulator
    logic          cand_v;
    logic [OW-1:0] cand_f, cand_l;
    logic          take_ins;

    logic [SW-1:0] out_slot;
    ffpa_pkg::t_seg tail;
    assign tail = chain[NS-1];

    logic [PW:0]   fa_page;
    logic [OW-1:0] fa_off;
    assign fa_page = (PW+1)'(i_free_addr >> OW);
    assign fa_off  = i_free_addr[OW-1:0];

    always_comb begin
        take_ins = 1'b0;
        cand_v   = 1'b0;
        cand_f   = rd_f;
        cand_l   = rd_l;
        if (!r_placed && (r_idx == r_k || rd_f > r_hs)) begin
            take_ins = 1'b1;
            cand_v   = 1'b1;
            cand_f   = r_if;
            cand_l   = r_il;
        end else if (r_idx != r_k) begin
            cand_v = 1'b1;
        end
    end

    always_comb begin
        seg_we = 1'b0;
        seg_wa = seg_addr(r_page, r_idx[SW-1:0]);
        seg_wd = {r_nf, r_nl};
        seg_ra = seg_addr(r_page, r_idx[SW-1:0]);
        bs_we  = 1'b0;
        bs_wa  = BAW'(r_page * ffpa_pkg::PAGE_BYTES + r_nf);
        bs_ra  = BAW'(r_page * ffpa_pkg::PAGE_BYTES + r_hs);
        chain_shift = 1'b0;
        chain_clr   = 1'b0;
        chain_in    = '{valid: 1'b1, first: r_tf, last: r_tl};
        out_slot    = r_idx[SW-1:0];
        case (r_state)
            S_A_WR: begin
                seg_we = 1'b1;
                seg_wa = seg_addr(r_page, out_slot);
                seg_wd = {r_nf + r_need[OW-1:0], r_nl};
                bs_we  = 1'b1;
            end
            S_F_HDR: chain_clr = 1'b1;
            S_F_MRG: begin
                if (cand_v && r_have && {1'b0, cand_f} > {1'b0, r_tl} + (OW+1)'(1)) begin
                    chain_shift = 1'b1;
                end
            end
            S_F_OUT: chain_shift = r_have;
            S_F_WR: begin
                seg_we = tail.valid;
                seg_wd = {tail.first, tail.last};
                seg_wa = seg_addr(r_page, r_idx[SW-1:0]);
                chain_shift = 1'b1;
                chain_in = clr_seg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_addr   <= '0;
            r_status <= ffpa_pkg::ST_OK;
            for (int p = 0; p < ffpa_pkg::NUM_PAGES; p++) begin
                r_open[p] <= 1'b0;
                r_cnt[p]  <= '0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_size <= i_req_size;
                        r_page <= '0;
                        r_idx  <= '0;
                        r_need <= (OW+1)'(i_req_size) + (OW+1)'(ffpa_pkg::HEADER_BYTES);
                        if (i_cmd == ffpa_pkg::CMD_ALLOC) begin
                            if (i_req_size == '0 ||
                                i_req_size > ffpa_pkg::SIZE_W'(ffpa_pkg::MAX_SIZE)) begin
                                r_addr   <= '0;
                                r_status <= ffpa_pkg::ST_BAD_SIZE;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_A_PAGE;
                            end
                        end else begin
                            if (fa_page >= (PW+1)'(ffpa_pkg::NUM_PAGES) ||
                                !r_open[fa_page[PW-1:0]] ||
                                fa_off < OW'(ffpa_pkg::HEADER_BYTES)) begin
                                r_addr   <= '0;
                                r_status <= ffpa_pkg::ST_BAD_ADDR;
                                r_state  <= S_DONE;
                            end else begin
                                r_page  <= fa_page[PW-1:0];
                                r_hs    <= fa_off - OW'(ffpa_pkg::HEADER_BYTES);
                                r_state <= S_F_HDR;
                            end
                        end
                    end
                end
                S_A_PAGE: begin
                    r_idx <= '0;
                    if (!r_open[r_page]) begin
                        r_open[r_page] <= 1'b1;
                        r_cnt[r_page]  <= CW'(1);
                        r_nf    <= '0;
                        r_nl    <= OW'(ffpa_pkg::PAGE_BYTES - 1);
                        r_state <= S_A_CHK;
                        r_nvalid <= 1'b1;
                    end else begin
                        r_nvalid <= 1'b0;
                        r_state <= (cur_cnt == '0) ? S_A_CHK : S_A_RD;
                    end
                end
                S_A_RD: begin
                    r_state  <= S_A_CHK;
                    r_nvalid <= 1'b0;
                end
                S_A_CHK: begin
                    if (r_nvalid || r_idx < cur_cnt) begin
                        if (r_nvalid ? ((OW+1)'(ffpa_pkg::PAGE_BYTES) > r_need)
                                     : (rd_l >= rd_f && seg_len > r_need)) begin
                            if (!r_nvalid) begin
                                r_nf <= rd_f;
                                r_nl <= rd_l;
                            end
                            r_state <= S_A_WR;
                        end else begin
                            r_nvalid <= 1'b0;
                            r_idx    <= r_idx + CW'(1);
                            r_state  <= (r_idx + CW'(1) < cur_cnt) ? S_A_RD : S_A_CHK;
                        end
                    end else if (r_page == PW'(ffpa_pkg::NUM_PAGES - 1)) begin
                        r_addr   <= '0;
                        r_status <= ffpa_pkg::ST_NO_SPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_page  <= r_page + PW'(1);
                        r_state <= S_A_PAGE;
                    end
                end
                S_A_WR: begin
                    r_nf     <= r_nf + r_need[OW-1:0];
                    r_addr   <= 14'(r_page * ffpa_pkg::PAGE_BYTES + r_nf
                                    + ffpa_pkg::HEADER_BYTES);
                    r_status <= ffpa_pkg::ST_OK;
                    r_state  <= S_DONE;
                end
                S_F_HDR: begin
                    r_state <= S_F_HDR2;
                end
                S_F_HDR2: begin
                    r_if     <= r_hs;
                    r_il     <= (last_sum > LW'(ffpa_pkg::PAGE_BYTES - 1))
                                ? OW'(ffpa_pkg::PAGE_BYTES - 1) : last_sum[OW-1:0];
                    r_k      <= cur_cnt;
                    r_idx    <= '0;
                    r_placed <= 1'b0;
                    r_have   <= 1'b0;
                    r_nvalid <= 1'b0;
                    r_state  <= S_F_RD;
                end
                S_F_RD: begin
                    r_state <= (r_idx == r_k && r_placed) ? S_F_OUT : S_F_MRG;
                end
                S_F_MRG: begin
                    if (!cand_v) begin
                        r_state <= S_F_OUT;
                    end else begin
                        if (take_ins) begin
                            r_placed <= 1'b1;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                        if (r_have && {1'b0, cand_f} <= {1'b0, r_tl} + (OW+1)'(1)) begin
                            if (cand_l > r_tl) r_tl <= cand_l;
                        end else begin
                            r_tf   <= cand_f;
                            r_tl   <= cand_l;
                            r_have <= 1'b1;
                        end
                        r_state <= (take_ins) ? S_F_MRG : S_F_RD;
                    end
                end
                S_F_OUT: begin
                    if (tail.valid) begin
                        r_addr   <= '0;
                        r_status <= ffpa_pkg::ST_NO_SPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_state <= S_F_WR;
                    end
                end
                S_F_WR: begin
                    if (tail.valid) begin
                        r_idx <= r_idx + CW'(1);
                        r_k   <= r_k + CW'(1);
                        r_nf  <= tail.first;
                        r_nl  <= tail.last;
                    end
                    if (!chain[NS-2].valid && (tail.valid || r_k != '0)) begin
                        if (r_k + (tail.valid ? CW'(1) : CW'(0)) == CW'(1) &&
                            (tail.valid ? tail.first : r_nf) == '0 &&
                            (tail.valid ? tail.last : r_nl) == OW'(ffpa_pkg::PAGE_BYTES - 1)) begin
                            r_open[r_page] <= 1'b0;
                            r_cnt[r_page]  <= '0;
                        end else begin
                            r_cnt[r_page] <= r_k + (tail.valid ? CW'(1) : CW'(0));
                        end
                        r_addr   <= '0;
                        r_status <= ffpa_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_block_addr = r_addr;
    assign o_status     = r_status;
endmodule

// ===== hdl/ffpa_checker.sv =====
// port-level checks for the allocator, bound to the top level
`timescale 1ns / 1ps
module ffpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [13:0] o_block_addr,
    input logic [1:0]  o_status
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("start not taken");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ffpa_pkg::ST_OK |-> o_block_addr == '0)
        else $error("failed result has an address");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
endmodule

bind first_fit_paged_allocator ffpa_checker u_ffpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_block_addr(o_block_addr), .o_status(o_status)
);
